@@ rtl/core/pgm16_stream_parser_core_assert.svh @@
// Assertion macros used by the parser RTL.
`ifndef PGM16_STREAM_PARSER_CORE_ASSERT_SVH
`define PGM16_STREAM_PARSER_CORE_ASSERT_SVH

// cond must hold in the same cycle whenever ante holds
`define PGM16_ASSERT_IMPLY(lbl, ck, rn, ante, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cond)) \
        else $error(msg);

// cond must hold in the cycle after ante
`define PGM16_ASSERT_NEXT(lbl, ck, rn, ante, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cond)) \
        else $error(msg);

// cond must never hold
`define PGM16_ASSERT_NEVER(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
        else $error(msg);

`endif

@@ rtl/core/pgm16_pkg.sv @@
package pgm16_pkg;

    localparam int MAX_DIM_DEFAULT = 65535;
    localparam int QUEUE_DEPTH     = 2;
    localparam int ACC_W           = 17;
    localparam int OUT_TDATA_W     = 56;

    localparam logic [ACC_W-1:0] ACC_MAX    = 17'h1FFFF;
    localparam logic [ACC_W-1:0] MAXVAL_REQ = 17'd65535;

    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_FIVE  = 8'h35;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_SPACE,
        CLS_NEWLINE,
        CLS_HASH,
        CLS_DIGIT,
        CLS_MAGIC_P
    } byte_class_t;

    typedef enum logic [3:0] {
        PH_MAGIC0,
        PH_MAGIC1,
        PH_SKIP,
        PH_DIGITS,
        PH_PIXELS,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        RK_HEADER = 2'd0,
        RK_SAMPLE = 2'd1,
        RK_ERROR  = 2'd2
    } result_kind_t;

    typedef enum logic [2:0] {
        ERR_TRUNCATED  = 3'd0,
        ERR_NOT_P5     = 3'd1,
        ERR_BAD_DIM    = 3'd2,
        ERR_MAXVAL     = 3'd3,
        ERR_SHORT_READ = 3'd4
    } error_code_t;

    // one classified input item, front to back
    typedef struct packed {
        logic [7:0]  data;
        logic        eos;
        byte_class_t cls;
    } item_t;

    typedef struct packed {
        result_kind_t kind;
        error_code_t  err;
        logic         last;
        logic [15:0]  sample;
        logic [15:0]  height;
        logic [15:0]  width;
    } result_t;

    function automatic byte_class_t classify(input logic [7:0] c);
        byte_class_t r;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
            r = CLS_DIGIT;
        else if (c == CHAR_NL)
            r = CLS_NEWLINE;
        else if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF ||
                 c == CHAR_CR)
            r = CLS_SPACE;
        else if (c == CHAR_HASH)
            r = CLS_HASH;
        else if (c == CHAR_P)
            r = CLS_MAGIC_P;
        else
            r = CLS_OTHER;
        return r;
    endfunction

endpackage

@@ rtl/core/pgm16_front.sv @@
// Input register stage: takes stream items and tags each byte with its class.
module pgm16_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // data_byte
    input  logic                s_axis_tuser,   // end_of_stream
    output logic                out_valid,
    input  logic                out_ready,
    output pgm16_pkg::item_t    out_item
);

    logic             valid_reg;
    logic             valid_next;
    pgm16_pkg::item_t item_reg;
    pgm16_pkg::item_t item_next;
    logic             accept;

    assign s_axis_tready = !valid_reg || out_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        item_next.data = s_axis_tdata;
        item_next.eos  = s_axis_tuser;
        item_next.cls  = pgm16_pkg::classify(s_axis_tdata);
        if (accept)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ rtl/core/pgm16_queue.sv @@
// Small FIFO of classified items between front and back.
module pgm16_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pgm16_pkg::item_t    in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output pgm16_pkg::item_t    out_item
);

    localparam int DEPTH = pgm16_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    pgm16_pkg::item_t  slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_item;
    end

endmodule

@@ rtl/core/pgm16_back.sv @@
`include "pgm16_stream_parser_core_assert.svh"

// Header parser and sample assembler, with the output register.
module pgm16_back #(
    parameter int MAX_DIM = pgm16_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  pgm16_pkg::item_t                      in_item,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [pgm16_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic [1:0]                            m_axis_tuser,
    output logic                                  m_axis_tlast
);

    localparam int AW = pgm16_pkg::ACC_W;

    pgm16_pkg::phase_t  phase_reg;
    pgm16_pkg::phase_t  phase_next;
    logic [1:0]         idx_reg;
    logic [1:0]         idx_next;
    logic               comment_reg;
    logic               comment_next;
    logic               parity_reg;
    logic               parity_next;
    logic [AW-1:0]      acc_reg;
    logic [AW-1:0]      acc_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic [15:0]        width_reg;
    logic [15:0]        width_next;
    logic [15:0]        height_reg;
    logic [15:0]        height_next;
    logic [7:0]         high_reg;
    logic [7:0]         high_next;
    logic [31:0]        samples_reg;
    logic [31:0]        samples_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    pgm16_pkg::result_t out_reg;
    pgm16_pkg::result_t res;
    logic               res_valid;

    logic               out_free;
    logic               step;
    logic               in_skip;
    logic               in_digits;
    logic               is_digit;
    logic               is_five;
    logic               skip_ignore;
    logic               take_digit;
    logic               num_end;
    logic [AW-1:0]      acc_base;
    logic [AW+3:0]      acc_raw;
    logic               acc_sat;
    logic [AW-1:0]      acc_sum;
    logic [AW-1:0]      num_val;
    logic               num_ovf;
    logic               dim_ok;
    logic               maxval_good;
    logic               dims_set;
    logic               hdr_ok;
    logic               last_now;
    pgm16_pkg::error_code_t hdr_err;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign in_ready = out_free;
    assign step     = in_valid && out_free;

    assign in_skip     = (phase_reg == pgm16_pkg::PH_SKIP);
    assign in_digits   = (phase_reg == pgm16_pkg::PH_DIGITS);
    assign is_digit    = (in_item.cls == pgm16_pkg::CLS_DIGIT);
    assign is_five     = (in_item.data == pgm16_pkg::CHAR_FIVE);
    assign skip_ignore = in_skip && (comment_reg || in_item.cls == pgm16_pkg::CLS_HASH ||
                         in_item.cls == pgm16_pkg::CLS_SPACE ||
                         in_item.cls == pgm16_pkg::CLS_NEWLINE);
    assign take_digit  = ((in_skip && !skip_ignore) || in_digits) && is_digit;
    assign num_end     = ((in_skip && !skip_ignore) || in_digits) && !is_digit;

    // acc * 10 + digit, saturating; a number begun from the skip phase starts at zero
    assign acc_base = in_skip ? '0 : acc_reg;
    assign acc_raw  = (AW+4)'({acc_base, 3'b000}) + (AW+4)'({acc_base, 1'b0}) +
                      (AW+4)'(in_item.data[3:0]);
    assign acc_sat  = acc_raw > (AW+4)'(pgm16_pkg::ACC_MAX);
    assign acc_sum  = acc_sat ? pgm16_pkg::ACC_MAX : acc_raw[AW-1:0];

    // a number ended straight from the skip phase reads as zero
    assign num_val     = in_skip ? '0 : acc_reg;
    assign num_ovf     = in_skip ? 1'b0 : ovf_reg;
    assign dim_ok      = !num_ovf && (num_val != '0) && (num_val <= AW'(MAX_DIM));
    assign maxval_good = !num_ovf && (num_val == pgm16_pkg::MAXVAL_REQ);
    assign dims_set    = (width_reg != '0) && (height_reg != '0);
    assign hdr_ok      = dims_set && maxval_good;
    assign hdr_err     = dims_set ? pgm16_pkg::ERR_MAXVAL : pgm16_pkg::ERR_BAD_DIM;
    assign last_now    = (samples_reg[31:1] == '0);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            if (in_item.eos)
                phase_next = pgm16_pkg::PH_MAGIC0;
            else
            begin
                case (phase_reg)
                    pgm16_pkg::PH_MAGIC0:
                        phase_next = (in_item.cls == pgm16_pkg::CLS_MAGIC_P) ?
                                     pgm16_pkg::PH_MAGIC1 : pgm16_pkg::PH_ERROR;
                    pgm16_pkg::PH_MAGIC1:
                        phase_next = is_five ? pgm16_pkg::PH_SKIP : pgm16_pkg::PH_ERROR;
                    pgm16_pkg::PH_SKIP,
                    pgm16_pkg::PH_DIGITS:
                    begin
                        if (num_end)
                        begin
                            if (idx_reg != 2'd2)
                                phase_next = pgm16_pkg::PH_SKIP;
                            else if (hdr_ok)
                                phase_next = pgm16_pkg::PH_PIXELS;
                            else
                                phase_next = pgm16_pkg::PH_ERROR;
                        end
                        else if (take_digit)
                            phase_next = pgm16_pkg::PH_DIGITS;
                    end
                    pgm16_pkg::PH_PIXELS:
                        if (parity_reg && last_now)
                            phase_next = pgm16_pkg::PH_DONE;
                    default:
                        phase_next = phase_reg;
                endcase
            end
        end
    end

    // datapath and results
    always_comb
    begin
        idx_next     = idx_reg;
        comment_next = comment_reg;
        parity_next  = parity_reg;
        acc_next     = acc_reg;
        ovf_next     = ovf_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        high_next    = high_reg;
        samples_next = samples_reg;
        res          = '0;
        res_valid    = 1'b0;
        if (step)
        begin
            if (in_item.eos)
            begin
                idx_next     = '0;
                comment_next = 1'b0;
                parity_next  = 1'b0;
                acc_next     = '0;
                ovf_next     = 1'b0;
                res.kind     = pgm16_pkg::RK_ERROR;
                case (phase_reg)
                    pgm16_pkg::PH_MAGIC0,
                    pgm16_pkg::PH_MAGIC1:
                    begin
                        res_valid = 1'b1;
                        res.err   = pgm16_pkg::ERR_NOT_P5;
                    end
                    pgm16_pkg::PH_SKIP:
                    begin
                        res_valid = 1'b1;
                        res.err   = pgm16_pkg::ERR_TRUNCATED;
                    end
                    pgm16_pkg::PH_DIGITS:
                    begin
                        res_valid = 1'b1;
                        if (idx_reg != 2'd2)
                            res.err = pgm16_pkg::ERR_TRUNCATED;
                        else if (hdr_ok)
                            res.err = pgm16_pkg::ERR_SHORT_READ;
                        else
                            res.err = hdr_err;
                    end
                    pgm16_pkg::PH_PIXELS:
                    begin
                        res_valid = 1'b1;
                        res.err   = pgm16_pkg::ERR_SHORT_READ;
                    end
                    default:
                        res_valid = 1'b0;
                endcase
            end
            else
            begin
                case (phase_reg)
                    pgm16_pkg::PH_MAGIC0:
                        if (in_item.cls != pgm16_pkg::CLS_MAGIC_P)
                        begin
                            res_valid = 1'b1;
                            res.kind  = pgm16_pkg::RK_ERROR;
                            res.err   = pgm16_pkg::ERR_NOT_P5;
                        end
                    pgm16_pkg::PH_MAGIC1:
                        if (is_five)
                        begin
                            idx_next     = '0;
                            comment_next = 1'b0;
                        end
                        else
                        begin
                            res_valid = 1'b1;
                            res.kind  = pgm16_pkg::RK_ERROR;
                            res.err   = pgm16_pkg::ERR_NOT_P5;
                        end
                    pgm16_pkg::PH_SKIP:
                        if (comment_reg)
                        begin
                            if (in_item.cls == pgm16_pkg::CLS_NEWLINE)
                                comment_next = 1'b0;
                        end
                        else if (in_item.cls == pgm16_pkg::CLS_HASH)
                            comment_next = 1'b1;
                    pgm16_pkg::PH_PIXELS:
                        if (!parity_reg)
                        begin
                            high_next   = in_item.data;
                            parity_next = 1'b1;
                        end
                        else
                        begin
                            parity_next = 1'b0;
                            res_valid   = 1'b1;
                            res.kind    = pgm16_pkg::RK_SAMPLE;
                            res.sample  = {high_reg, in_item.data};
                            res.last    = last_now;
                            if (samples_reg != '0)
                                samples_next = samples_reg - 1'b1;
                        end
                    default:
                        res_valid = 1'b0;
                endcase

                if (take_digit)
                begin
                    acc_next = acc_sum;
                    ovf_next = num_ovf | acc_sat;
                end

                if (num_end)
                begin
                    acc_next     = '0;
                    ovf_next     = 1'b0;
                    comment_next = 1'b0;
                    case (idx_reg)
                        2'd0:
                        begin
                            width_next = dim_ok ? num_val[15:0] : '0;
                            idx_next   = 2'd1;
                        end
                        2'd1:
                        begin
                            height_next = dim_ok ? num_val[15:0] : '0;
                            idx_next    = 2'd2;
                        end
                        default:
                        begin
                            idx_next  = '0;
                            res_valid = 1'b1;
                            if (hdr_ok)
                            begin
                                res.kind     = pgm16_pkg::RK_HEADER;
                                res.width    = width_reg;
                                res.height   = height_reg;
                                samples_next = 32'(width_reg) * 32'(height_reg);
                                parity_next  = 1'b0;
                                high_next    = '0;
                            end
                            else
                            begin
                                res.kind = pgm16_pkg::RK_ERROR;
                                res.err  = hdr_err;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        if (out_free)
            out_valid_next = step && res_valid;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pgm16_pkg::PH_MAGIC0;
            idx_reg       <= '0;
            comment_reg   <= 1'b0;
            parity_reg    <= 1'b0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            comment_reg   <= comment_next;
            parity_reg    <= parity_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg   <= width_next;
        height_reg  <= height_next;
        high_reg    <= high_next;
        samples_reg <= samples_next;
        if (step && res_valid)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_reg.err, out_reg.sample, out_reg.height, out_reg.width};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;

    `PGM16_ASSERT_NEVER(a_idx_range, clk, rst_n, idx_reg == 2'd3,
        "number index out of range")
    `PGM16_ASSERT_IMPLY(a_pixels_count, clk, rst_n, phase_reg == pgm16_pkg::PH_PIXELS,
        samples_reg != '0, "sample count ran out during payload")
    `PGM16_ASSERT_IMPLY(a_comment_phase, clk, rst_n, comment_reg,
        phase_reg == pgm16_pkg::PH_SKIP, "comment flag outside skip phase")
    `PGM16_ASSERT_NEXT(a_eos_rearm, clk, rst_n, step && in_item.eos,
        phase_reg == pgm16_pkg::PH_MAGIC0 && idx_reg == '0 && !parity_reg,
        "end of stream did not re-arm parser")

endmodule

@@ rtl/core/pgm16_stream_parser_core.sv @@
// Binary 16-bit PGM (P5) stream parser.
// Input channel s_axis: one file byte per item in tdata; tuser high marks an
// end-of-stream item (no byte); it reports a not-P5, truncation, header or
// short-read error if the file stopped early, always re-arming for the next file.
// Output channel m_axis: at most one item per input item. tuser gives the
// kind (header, sample, error); tdata carries width, height, sample and error
// code, unused fields zero; tlast flags the final sample of the image.
// A result passes the input register, a queue slot and the output register
// on its way to m_axis.
// Throughput: one byte per cycle sustained while m_axis_tready is high; the
// parser stage does one byte's state update, x10 digit accumulate included, in
// a single cycle. The pixel count width*height is multiplied once, at header accept.
// Reset (rst_n low, asynchronous) empties the input stage and queue, drops
// tvalid and puts the parser back to expecting the 'P' magic byte.
// When the receiver holds m_axis_tready low the output item is held, the
// parser stops, the queue fills and s_axis_tready falls once the queue and the
// input register hold three items in all.
module pgm16_stream_parser_core #(
    parameter int MAX_DIM = pgm16_pkg::MAX_DIM_DEFAULT  // largest accepted dimension
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] data_byte
    input  logic                              s_axis_tuser,   // [0] end_of_stream
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] image_width, [31:16] image_height, [47:32] sample_value,
    // [50:48] error_code, [55:51] zero
    output logic [pgm16_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]                        m_axis_tuser,   // [1:0] result_kind
    output logic                              m_axis_tlast    // last_sample
);

    // front stage -> queue
    logic             fr_valid;
    logic             fr_ready;
    pgm16_pkg::item_t fr_item;

    // queue -> parser
    logic             q_valid;
    logic             q_ready;
    pgm16_pkg::item_t q_item;

    pgm16_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .out_valid     (fr_valid),
        .out_ready     (fr_ready),
        .out_item      (fr_item)
    );

    pgm16_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    pgm16_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (q_valid),
        .in_ready      (q_ready),
        .in_item       (q_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ test/testbench.sv @@
module testbench;

    localparam int STIM_ITEMS   = 1650;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_STEP    = 700;
    localparam int DRAIN_CYCLES = 16;
    localparam int DIM_LIMIT    = pgm16_pkg::MAX_DIM_DEFAULT;
    localparam int TDATA_W      = pgm16_pkg::OUT_TDATA_W;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } file_item_t;

    logic               clk;
    logic               rst_n         = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = 8'h00;
    logic               s_axis_tuser  = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [1:0]         m_axis_tuser;
    logic               m_axis_tlast;

    pgm16_stream_parser_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // bytes waiting to be sent, and parse results waiting to come out
    file_item_t          file_bytes_q[$];
    pgm16_pkg::result_t  parse_results_q[$];

    int  mismatches = 0;
    int  bytes_in   = 0;
    int  cycles     = 0;
    bit  in_taken   = 1'b0;

    // ------------------------------------------------------------------
    // Parser model state
    // ------------------------------------------------------------------
    pgm16_pkg::phase_t pr_phase;
    logic [1:0]        pr_field;
    logic              pr_in_cmt;
    logic [16:0]       pr_acc;
    logic              pr_ovf;
    logic [15:0]       pr_width;
    logic [15:0]       pr_height;
    logic              pr_max_ok;
    logic [7:0]        pr_high;
    logic              pr_odd;
    logic [31:0]       pr_left;

    function automatic bit is_blank(input logic [7:0] c);
        return c == pgm16_pkg::CHAR_SPACE || c == pgm16_pkg::CHAR_TAB ||
               c == pgm16_pkg::CHAR_NL || c == pgm16_pkg::CHAR_VT ||
               c == pgm16_pkg::CHAR_FF || c == pgm16_pkg::CHAR_CR;
    endfunction

    function automatic bit is_num_char(input logic [7:0] c);
        return c >= pgm16_pkg::CHAR_ZERO && c <= pgm16_pkg::CHAR_NINE;
    endfunction

    task automatic pr_reset();
        pr_phase  = pgm16_pkg::PH_MAGIC0;
        pr_field  = 2'd0;
        pr_in_cmt = 1'b0;
        pr_acc    = '0;
        pr_ovf    = 1'b0;
        pr_width  = '0;
        pr_height = '0;
        pr_max_ok = 1'b0;
        pr_high   = '0;
        pr_odd    = 1'b0;
        pr_left   = '0;
    endtask

    task automatic pr_fail(input pgm16_pkg::error_code_t code, output pgm16_pkg::result_t r);
        r        = '0;
        r.kind   = pgm16_pkg::RK_ERROR;
        r.err    = code;
        pr_phase = pgm16_pkg::PH_ERROR;
    endtask

    // all three numbers read: dimensions are checked before maxval
    task automatic pr_header(output bit got, output pgm16_pkg::result_t r);
        got = 1'b1;
        r   = '0;
        if (pr_width == 0 || pr_height == 0)
            pr_fail(pgm16_pkg::ERR_BAD_DIM, r);
        else if (!pr_max_ok)
            pr_fail(pgm16_pkg::ERR_MAXVAL, r);
        else
        begin
            r.kind   = pgm16_pkg::RK_HEADER;
            r.width  = pr_width;
            r.height = pr_height;
            pr_left  = {16'd0, pr_width} * {16'd0, pr_height};
            pr_odd   = 1'b0;
            pr_high  = '0;
            pr_phase = pgm16_pkg::PH_PIXELS;
        end
    endtask

    task automatic pr_end_number(output bit got, output pgm16_pkg::result_t r);
        logic [16:0] v;
        bit          dim_ok;
        v         = pr_acc;
        dim_ok    = !pr_ovf && v >= 1 && v <= DIM_LIMIT;
        got       = 1'b0;
        r         = '0;
        pr_acc    = '0;
        pr_in_cmt = 1'b0;
        if (pr_field == 2'd0)
        begin
            pr_width = dim_ok ? v[15:0] : 16'd0;
            pr_field = 2'd1;
            pr_phase = pgm16_pkg::PH_SKIP;
        end
        else if (pr_field == 2'd1)
        begin
            pr_height = dim_ok ? v[15:0] : 16'd0;
            pr_field  = 2'd2;
            pr_phase  = pgm16_pkg::PH_SKIP;
        end
        else
        begin
            pr_max_ok = !pr_ovf && v == 17'd65535;
            pr_field  = 2'd0;
            pr_header(got, r);
        end
        pr_ovf = 1'b0;
    endtask

    // decimal accumulate, saturating with the overflow flag set
    task automatic pr_digit(input logic [7:0] c);
        logic [31:0] n;
        n = {15'd0, pr_acc} * 32'd10 + {24'd0, c} - {24'd0, pgm16_pkg::CHAR_ZERO};
        if (n > {15'd0, pgm16_pkg::ACC_MAX})
        begin
            n      = {15'd0, pgm16_pkg::ACC_MAX};
            pr_ovf = 1'b1;
        end
        pr_acc = n[16:0];
    endtask

    task automatic parse_byte(input logic [7:0] c, input logic eos, output bit got,
                              output pgm16_pkg::result_t r);
        got = 1'b0;
        r   = '0;
        if (eos)
        begin
            case (pr_phase)
                pgm16_pkg::PH_MAGIC0, pgm16_pkg::PH_MAGIC1:
                begin
                    pr_fail(pgm16_pkg::ERR_NOT_P5, r);
                    got = 1'b1;
                end
                pgm16_pkg::PH_SKIP:
                begin
                    pr_fail(pgm16_pkg::ERR_TRUNCATED, r);
                    got = 1'b1;
                end
                pgm16_pkg::PH_DIGITS:
                begin
                    if (pr_field == 2'd2)
                    begin
                        // maxval ends at the stream end: header checks, else no payload
                        pr_end_number(got, r);
                        if (r.kind == pgm16_pkg::RK_HEADER)
                            pr_fail(pgm16_pkg::ERR_SHORT_READ, r);
                    end
                    else
                    begin
                        pr_fail(pgm16_pkg::ERR_TRUNCATED, r);
                        got = 1'b1;
                    end
                end
                pgm16_pkg::PH_PIXELS:
                begin
                    pr_fail(pgm16_pkg::ERR_SHORT_READ, r);
                    got = 1'b1;
                end
                default:
                    ;
            endcase
            pr_reset();
        end
        else
        begin
            case (pr_phase)
                pgm16_pkg::PH_MAGIC0:
                begin
                    if (c != pgm16_pkg::CHAR_P)
                    begin
                        pr_fail(pgm16_pkg::ERR_NOT_P5, r);
                        got = 1'b1;
                    end
                    else
                        pr_phase = pgm16_pkg::PH_MAGIC1;
                end
                pgm16_pkg::PH_MAGIC1:
                begin
                    if (c != pgm16_pkg::CHAR_FIVE)
                    begin
                        pr_fail(pgm16_pkg::ERR_NOT_P5, r);
                        got = 1'b1;
                    end
                    else
                    begin
                        pr_phase  = pgm16_pkg::PH_SKIP;
                        pr_field  = 2'd0;
                        pr_in_cmt = 1'b0;
                    end
                end
                pgm16_pkg::PH_SKIP:
                begin
                    if (pr_in_cmt)
                    begin
                        if (c == pgm16_pkg::CHAR_NL)
                            pr_in_cmt = 1'b0;
                    end
                    else if (c == pgm16_pkg::CHAR_HASH)
                        pr_in_cmt = 1'b1;
                    else if (!is_blank(c))
                    begin
                        pr_acc = '0;
                        pr_ovf = 1'b0;
                        if (is_num_char(c))
                        begin
                            pr_digit(c);
                            pr_phase = pgm16_pkg::PH_DIGITS;
                        end
                        else
                            pr_end_number(got, r);   // non-digit: number is 0
                    end
                end
                pgm16_pkg::PH_DIGITS:
                begin
                    if (is_num_char(c))
                        pr_digit(c);
                    else
                        pr_end_number(got, r);
                end
                pgm16_pkg::PH_PIXELS:
                begin
                    if (!pr_odd)
                    begin
                        pr_high = c;
                        pr_odd  = 1'b1;
                    end
                    else
                    begin
                        pr_odd   = 1'b0;
                        got      = 1'b1;
                        r.kind   = pgm16_pkg::RK_SAMPLE;
                        r.sample = {pr_high, c};
                        if (pr_left != 0)
                            pr_left = pr_left - 1;
                        if (pr_left == 0)
                        begin
                            r.last   = 1'b1;
                            pr_phase = pgm16_pkg::PH_DONE;
                        end
                    end
                end
                default:
                    ;
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // File builders
    // ------------------------------------------------------------------
    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 7))
            0:       return pgm16_pkg::CHAR_TAB;
            1:       return pgm16_pkg::CHAR_NL;
            2:       return pgm16_pkg::CHAR_VT;
            3:       return pgm16_pkg::CHAR_FF;
            4:       return pgm16_pkg::CHAR_CR;
            default: return pgm16_pkg::CHAR_SPACE;
        endcase
    endfunction

    // a byte that is neither digit, whitespace nor comment start
    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (is_num_char(b) || is_blank(b) || b == pgm16_pkg::CHAR_HASH);
        return b;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic eos);
        file_item_t it;
        it.data = b;
        it.eos  = eos;
        file_bytes_q.push_back(it);
    endtask

    task automatic push_eos();
        push_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], 1'b0);
    endtask

    // random payload, biased toward the byte extremes
    task automatic push_pixels(input longint n);
        for (longint i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0:       push_byte(8'h00, 1'b0);
                1:       push_byte(8'hFF, 1'b0);
                default: push_byte(8'($urandom_range(0, 255)), 1'b0);
            endcase
        end
    endtask

    // one header number: optional whitespace/comments, digits, one delimiter.
    // A negative value sends a non-digit where the number starts.
    task automatic push_field(input longint v, input bit is_maxval);
        logic [7:0] cb;
        repeat ($urandom_range(0, 2))
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                push_byte(pgm16_pkg::CHAR_HASH, 1'b0);
                repeat ($urandom_range(0, 5))
                begin
                    do
                        cb = 8'($urandom_range(0, 255));
                    while (cb == pgm16_pkg::CHAR_NL);
                    push_byte(cb, 1'b0);
                end
                push_byte(pgm16_pkg::CHAR_NL, 1'b0);
            end
            else
                push_byte(blank_byte(), 1'b0);
        end
        if (v < 0)
            push_byte(junk_byte(), 1'b0);
        else
        begin
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 3))
                    push_byte(pgm16_pkg::CHAR_ZERO, 1'b0);
            push_text($sformatf("%0d", v));
            case ($urandom_range(0, 7))
                0:       push_byte(pgm16_pkg::CHAR_HASH, 1'b0);   // hash right after digits
                1:       push_byte(is_maxval ? blank_byte() : junk_byte(), 1'b0);
                default: push_byte(blank_byte(), 1'b0);
            endcase
        end
    endtask

    task automatic push_header(input longint wv, input longint hv, input longint mv);
        push_text("P5");
        push_field(wv, 1'b0);
        push_field(hv, 1'b0);
        push_field(mv, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Clock, reset, stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
            #6 clk = ~clk;
    end

    initial
    begin
        longint     wv;
        longint     hv;
        longint     mv;
        int         pick;
        int         cut;
        int         start;
        int         n_directed;
        logic [7:0] b;

        pr_reset();

        // directed: minimal image with extreme sample bytes, then stream end
        // in the done state, at the first magic byte, and after a bad magic
        push_text("P5 1 1 65535\n");
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_eos();
        push_eos();
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_eos();
        n_directed = file_bytes_q.size();

        while (file_bytes_q.size() < n_directed + STIM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            wv   = $urandom_range(1, 4);
            hv   = $urandom_range(1, 4);
            if ($urandom_range(0, 7) == 0)
            begin
                wv = $urandom_range(5, 24);
                hv = 1;
            end
            if (pick < 55)
            begin
                // complete image, sometimes with trailing bytes that are ignored
                push_header(wv, hv, 65535);
                push_pixels(2 * wv * hv);
                if ($urandom_range(0, 2) == 0)
                    push_pixels($urandom_range(1, 6));
                push_eos();
            end
            else if (pick < 65)
            begin
                // payload cut short, possibly with a pending high byte
                if ($urandom_range(0, 2) == 0)
                begin
                    wv = DIM_LIMIT;
                    hv = $urandom_range(0, 1) ? DIM_LIMIT : 1;
                end
                push_header(wv, hv, 65535);
                cut = $urandom_range(0, 11);
                if (cut >= 2 * wv * hv)
                    cut = int'(2 * wv * hv - 1);
                push_pixels(cut);
                push_eos();
            end
            else if (pick < 72)
            begin
                // header cut at a random byte
                if ($urandom_range(0, 3) == 0)
                    wv = 0;
                mv    = $urandom_range(0, 3) == 0 ? 255 : 65535;
                start = file_bytes_q.size();
                push_header(wv, hv, mv);
                cut = $urandom_range(0, file_bytes_q.size() - start - 1);
                while (file_bytes_q.size() > start + cut)
                    file_bytes_q.delete(file_bytes_q.size() - 1);
                push_eos();
            end
            else if (pick < 78)
            begin
                if ($urandom_range(0, 1))
                begin
                    push_byte(pgm16_pkg::CHAR_P, 1'b0);
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == pgm16_pkg::CHAR_FIVE);
                end
                else
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == pgm16_pkg::CHAR_P);
                end
                push_byte(b, 1'b0);
                push_pixels($urandom_range(0, 6));
                push_eos();
            end
            else if (pick < 88)
            begin
                // bad dimensions; a bad maxval too must still report dimensions
                case ($urandom_range(0, 6))
                    0:       wv = 0;
                    1:       hv = 0;
                    2:       wv = DIM_LIMIT + 1;
                    3:       hv = $urandom_range(131071, 131072);
                    4:       wv = 99999999;
                    5:       wv = -1;
                    default:
                    begin
                        wv = DIM_LIMIT;
                        hv = -1;
                    end
                endcase
                mv = $urandom_range(0, 2) == 0 ? 255 : 65535;
                push_header(wv, hv, mv);
                push_pixels($urandom_range(0, 4));
                push_eos();
            end
            else if (pick < 95)
            begin
                case ($urandom_range(0, 6))
                    0:       mv = 0;
                    1:       mv = 255;
                    2:       mv = 65534;
                    3:       mv = 65536;
                    4:       mv = 131071;
                    5:       mv = 99999999;
                    default: mv = -1;
                endcase
                push_header(wv, hv, mv);
                push_pixels($urandom_range(0, 4));
                push_eos();
            end
            else
            begin
                // noise, sometimes behind a valid magic
                if ($urandom_range(0, 1))
                    push_text("P5");
                push_pixels($urandom_range(0, 20));
                push_eos();
            end
        end

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (file_bytes_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (parse_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatches == 0 && parse_results_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Byte sender: bursts of random length with random gaps
    // ------------------------------------------------------------------
    int         burst_left = 1;
    int         gap_left   = 0;
    file_item_t next_byte;

    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (gap_left != 0 || file_bytes_q.size() == 0)
            begin
                if (gap_left != 0)
                    gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                next_byte = file_bytes_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_byte.data;
                s_axis_tuser  <= next_byte.eos;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(0, 7) == 0 ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 24);
                    gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: changing stall patterns plus long hold-offs that
    // back the parser up into its input
    // ------------------------------------------------------------------
    int hold_left = 0;
    int hold_mark = 300;
    int seg_left  = 0;
    int rx_mode   = 0;
    int rx_tick   = 0;

    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (bytes_in >= hold_mark)
        begin
            hold_left = HOLD_CYCLES;
            hold_mark = hold_mark + HOLD_STEP;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (seg_left == 0)
            begin
                rx_mode  = $urandom_range(0, 3);
                seg_left = $urandom_range(16, 96);
            end
            else
                seg_left--;
            rx_tick++;
            case (rx_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= $urandom_range(0, 3) == 0;
                default: m_axis_tready <= rx_tick % 3 == 0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check outputs, then predict from the accepted input byte
    // ------------------------------------------------------------------
    task automatic log_mismatch(input string tag, input pgm16_pkg::result_t want,
                                input pgm16_pkg::result_t saw);
        mismatches++;
        if (mismatches <= 10)
        begin
            $write("%s: want kind=%0d w=%0d h=%0d s=%h last=%0b err=%0d | ",
                   tag, want.kind, want.width, want.height, want.sample, want.last,
                   want.err);
            $display("got kind=%0d w=%0d h=%0d s=%h last=%0b err=%0d pad=%h",
                     saw.kind, saw.width, saw.height, saw.sample, saw.last, saw.err,
                     m_axis_tdata[55:51]);
        end
    endtask

    pgm16_pkg::result_t seen;
    pgm16_pkg::result_t want;
    pgm16_pkg::result_t pred;
    bit                 pred_got;

    always @(posedge clk)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;

            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.kind   = pgm16_pkg::result_kind_t'(m_axis_tuser);
                seen.err    = pgm16_pkg::error_code_t'(m_axis_tdata[50:48]);
                seen.last   = m_axis_tlast;
                seen.sample = m_axis_tdata[47:32];
                seen.height = m_axis_tdata[31:16];
                seen.width  = m_axis_tdata[15:0];
                if (parse_results_q.size() == 0)
                    log_mismatch("unexpected item", '0, seen);
                else
                begin
                    want = parse_results_q.pop_front();
                    if (seen !== want || m_axis_tdata[55:51] !== 5'd0)
                        log_mismatch("mismatch", want, seen);
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                bytes_in++;
                parse_byte(s_axis_tdata, s_axis_tuser, pred_got, pred);
                if (pred_got)
                    parse_results_q.push_back(pred);
            end
        end
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/pgm16_pkg.sv
rtl/core/pgm16_front.sv
rtl/core/pgm16_queue.sv
rtl/core/pgm16_back.sv
rtl/core/pgm16_stream_parser_core.sv
test/testbench.sv
